// ----- src/dtag_pkg.sv -----
// Shared types, constants and the arctangent table of the displacement address generator.
`timescale 1ns / 1ps

package dtag_pkg;

   // Fixed-point formats of the coordinate stream.
   localparam int COORD_FRAC_BITS = 16;
   localparam int COORD_WIDTH     = 20;
   localparam int PHASE_WIDTH     = 16;
   localparam int FRAC_WIDTH      = 5;
   localparam int INDEX_WIDTH     = 22;
   localparam int PACKED_WIDTH    = 32;
   localparam int SIZE_WIDTH      = 12;
   localparam int HALF_WIDTH      = SIZE_WIDTH - 1;
   localparam int DIAG_WIDTH      = 27;

   // Request bus width, rounded up to whole bytes.
   localparam int REQ_BITS  = 3 * COORD_WIDTH + PHASE_WIDTH;
   localparam int REQ_BYTES = (REQ_BITS + 7) / 8;
   localparam int REQ_DATA_WIDTH = REQ_BYTES * 8;

   // Position word and its integer part.
   localparam int POS_WIDTH = 32;
   localparam int COL_BITS  = POS_WIDTH - COORD_FRAC_BITS;
   localparam int COL_OUT_WIDTH = SIZE_WIDTH - 1;

   // Pipeline shape.
   localparam int CORDIC_STEPS        = 16;
   localparam int CORDIC_STAGES       = CORDIC_STEPS + 1;
   localparam int SCALE_STAGES        = 3;
   localparam int MOD_STAGES          = 4;
   localparam int MOD_BITS_PER_STAGE  = COL_BITS / MOD_STAGES;
   localparam int WRAP_STAGES         = MOD_STAGES + 3;
   localparam int PIPE_STAGES         = CORDIC_STAGES + SCALE_STAGES + WRAP_STAGES;

   // CORDIC constants: angles are in 2^-32 turn, the vector in Q30.
   localparam int CORDIC_WIDTH = 33;
   localparam int TRIG_SHIFT   = 6;
   localparam int TRIG_WIDTH   = CORDIC_WIDTH - TRIG_SHIFT;
   localparam int TRIG_FRAC    = 24;
   localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
   localparam logic [PHASE_WIDTH-1:0] QUARTER_TURN = 16'd16384;

   // Largest subpixel fraction.
   localparam logic [FRAC_WIDTH-1:0] FRAC_MAX = 5'd31;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = DIAG_WIDTH;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_FRAME_WIDTH   = 3'd0,
      REG_FRAME_HEIGHT  = 3'd1,
      REG_WRAP_MODE     = 3'd2,
      REG_SUBPIXEL_MODE = 3'd3,
      REG_RECT_MODE     = 3'd4,
      REG_HALF_DIAGONAL = 3'd5
   } csr_index_type;

   // Effective configuration seen by the datapath.
   typedef struct packed {
      logic [SIZE_WIDTH-1:0] width;
      logic [SIZE_WIDTH-1:0] height;
      logic [HALF_WIDTH-1:0] half_w;
      logic [HALF_WIDTH-1:0] half_h;
      logic                  wrap;
      logic                  subpixel;
      logic                  rect;
      logic [DIAG_WIDTH-1:0] half_diag;
   } cfg_type;

   // Coordinate fields carried alongside the CORDIC.
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ndc_x;
      logic signed [COORD_WIDTH-1:0] ndc_y;
      logic signed [COORD_WIDTH-1:0] norm_dist;
   } payload_type;

   // One axis on its way through the remainder pipeline.
   typedef struct packed {
      logic                     neg;
      logic [COL_BITS-1:0]      mag;
      logic [FRAC_WIDTH-1:0]    frac;
      logic [COL_OUT_WIDTH-1:0] rem;
   } axis_type;

   // Arctangent of 2^-i in 2^-32 turn.
   function automatic logic [31:0] atan_turns(input int idx);
      logic [31:0] val;
      case (idx)
         0:  val = 32'h20000000;
         1:  val = 32'h12E4051E;
         2:  val = 32'h09FB385B;
         3:  val = 32'h051111D4;
         4:  val = 32'h028B0D43;
         5:  val = 32'h0145D7E1;
         6:  val = 32'h00A2F61E;
         7:  val = 32'h00517C55;
         8:  val = 32'h0028BE53;
         9:  val = 32'h00145F2F;
         10: val = 32'h000A2F98;
         11: val = 32'h000517CC;
         12: val = 32'h00028BE6;
         13: val = 32'h000145F3;
         14: val = 32'h0000A2FA;
         15: val = 32'h0000517D;
         16: val = 32'h000028BE;
         17: val = 32'h0000145F;
         18: val = 32'h00000A30;
         19: val = 32'h00000518;
         20: val = 32'h0000028C;
         21: val = 32'h00000146;
         22: val = 32'h000000A3;
         23: val = 32'h00000051;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

// ----- src/dtag_cordic.sv -----
// Pipelined CORDIC that turns the phase into cosine and sine: an entry stage, then one rotation per stage.
`timescale 1ns / 1ps

module dtag_cordic (
   input  logic                                    clock,
   input  logic [dtag_pkg::CORDIC_STAGES-1:0]      stage_en,
   input  dtag_pkg::payload_type                   in_pay,
   input  logic [dtag_pkg::PHASE_WIDTH-1:0]        in_phase,
   output logic signed [dtag_pkg::CORDIC_WIDTH-1:0] out_x,
   output logic signed [dtag_pkg::CORDIC_WIDTH-1:0] out_y,
   output logic                                    out_neg,
   output dtag_pkg::payload_type                   out_pay
);

   localparam int W = dtag_pkg::CORDIC_WIDTH;
   localparam int N = dtag_pkg::CORDIC_STEPS;

   logic signed [W-1:0]   x_ff   [N+1];
   logic signed [W-1:0]   y_ff   [N+1];
   logic signed [W-1:0]   z_ff   [N+1];
   logic                  neg_ff [N+1];
   dtag_pkg::payload_type pay_ff [N+1];

   logic [dtag_pkg::PHASE_WIDTH-1:0] phase_in;
   logic [31:0]                      angle_in;
   logic                             fold_in;
   logic [31:0]                      angle_fold_in;

   // Start angle is the phase minus a quarter turn; the back half is folded by a half turn.
   always_comb begin
      phase_in      = in_phase - dtag_pkg::QUARTER_TURN;
      angle_in      = {phase_in, 16'h0000};
      fold_in       = angle_in[31] ^ angle_in[30];
      angle_fold_in = {angle_in[31] ^ fold_in, angle_in[30:0]};
   end

   // Entry stage.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x_ff[0]   <= W'(dtag_pkg::CORDIC_GAIN_Q30);
         y_ff[0]   <= '0;
         z_ff[0]   <= $signed({angle_fold_in[31], angle_fold_in});
         neg_ff[0] <= fold_in;
         pay_ff[0] <= in_pay;
      end
   end

   // One rotation step per stage.
   for (genvar k = 0; k < N; k++) begin : g_step
      logic signed [W-1:0] dx_in;
      logic signed [W-1:0] dy_in;
      logic signed [W-1:0] atan_in;
      logic signed [W-1:0] x_in;
      logic signed [W-1:0] y_in;
      logic signed [W-1:0] z_in;

      always_comb begin
         dx_in   = y_ff[k] >>> k;
         dy_in   = x_ff[k] >>> k;
         atan_in = $signed({1'b0, dtag_pkg::atan_turns(k)});
         if (!z_ff[k][W-1]) begin
            x_in = x_ff[k] - dx_in;
            y_in = y_ff[k] + dy_in;
            z_in = z_ff[k] - atan_in;
         end else begin
            x_in = x_ff[k] + dx_in;
            y_in = y_ff[k] - dy_in;
            z_in = z_ff[k] + atan_in;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[k+1]) begin
            x_ff[k+1]   <= x_in;
            y_ff[k+1]   <= y_in;
            z_ff[k+1]   <= z_in;
            neg_ff[k+1] <= neg_ff[k];
            pay_ff[k+1] <= pay_ff[k];
         end
      end
   end

   assign out_x   = x_ff[N];
   assign out_y   = y_ff[N];
   assign out_neg = neg_ff[N];
   assign out_pay = pay_ff[N];

endmodule

// ----- src/dtag_scale.sv -----
// Maps the coordinates to fixed-point pixel positions in rect or polar mode.
`timescale 1ns / 1ps

module dtag_scale (
   input  logic                                     clock,
   input  logic [dtag_pkg::SCALE_STAGES-1:0]        stage_en,
   input  dtag_pkg::cfg_type                        cfg,
   input  logic signed [dtag_pkg::CORDIC_WIDTH-1:0] in_x,
   input  logic signed [dtag_pkg::CORDIC_WIDTH-1:0] in_y,
   input  logic                                     in_neg,
   input  dtag_pkg::payload_type                    in_pay,
   output logic signed [dtag_pkg::POS_WIDTH-1:0]    pos_x,
   output logic signed [dtag_pkg::POS_WIDTH-1:0]    pos_y
);

   localparam int F     = dtag_pkg::COORD_FRAC_BITS;
   localparam int CW    = dtag_pkg::CORDIC_WIDTH;
   localparam int TW    = dtag_pkg::TRIG_WIDTH;
   localparam int PW    = dtag_pkg::POS_WIDTH;
   localparam int OFS_W = dtag_pkg::COORD_WIDTH + 1;
   localparam int DPW   = dtag_pkg::COORD_WIDTH + dtag_pkg::DIAG_WIDTH + 1;
   localparam int DQW   = DPW - 1 - F;
   localparam int MPW   = DQW + TW;
   localparam int RPW   = OFS_W + dtag_pkg::HALF_WIDTH + 1;

   // Stage 0: trig values, scaled distance and the rect products.
   logic signed [CW-1:0]    tx_in;
   logic signed [CW-1:0]    ty_in;
   logic signed [DPW-1:0]   dist_prod_in;
   logic signed [OFS_W-1:0] ofs_x_in;
   logic signed [OFS_W-1:0] ofs_y_in;
   logic signed [RPW-1:0]   rect_x_prod_in;
   logic signed [RPW-1:0]   rect_y_prod_in;

   logic signed [TW-1:0]  cos_ff;
   logic signed [TW-1:0]  sin_ff;
   logic signed [DQW-1:0] dq_ff;
   logic signed [PW-1:0]  rect_x0_ff;
   logic signed [PW-1:0]  rect_y0_ff;

   always_comb begin
      tx_in          = in_neg ? -in_x : in_x;
      ty_in          = in_neg ? -in_y : in_y;
      dist_prod_in   = in_pay.norm_dist * $signed({1'b0, cfg.half_diag});
      ofs_x_in       = $signed({in_pay.ndc_x[dtag_pkg::COORD_WIDTH-1], in_pay.ndc_x})
                       + $signed(OFS_W'(1 << F));
      ofs_y_in       = $signed({in_pay.ndc_y[dtag_pkg::COORD_WIDTH-1], in_pay.ndc_y})
                       + $signed(OFS_W'(1 << F));
      rect_x_prod_in = ofs_x_in * $signed({1'b0, cfg.half_w});
      rect_y_prod_in = ofs_y_in * $signed({1'b0, cfg.half_h});
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cos_ff     <= tx_in[CW-1:dtag_pkg::TRIG_SHIFT];
         sin_ff     <= ty_in[CW-1:dtag_pkg::TRIG_SHIFT];
         dq_ff      <= dist_prod_in[DPW-2:F];
         rect_x0_ff <= rect_x_prod_in[PW-1:0];
         rect_y0_ff <= rect_y_prod_in[PW-1:0];
      end
   end

   // Stage 1: rotate the scaled distance.
   logic signed [MPW-1:0] mul_x_in;
   logic signed [MPW-1:0] mul_y_in;
   logic signed [PW-1:0]  off_x_ff;
   logic signed [PW-1:0]  off_y_ff;
   logic signed [PW-1:0]  rect_x1_ff;
   logic signed [PW-1:0]  rect_y1_ff;

   always_comb begin
      mul_x_in = dq_ff * cos_ff;
      mul_y_in = dq_ff * sin_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         off_x_ff   <= mul_x_in[dtag_pkg::TRIG_FRAC +: PW];
         off_y_ff   <= mul_y_in[dtag_pkg::TRIG_FRAC +: PW];
         rect_x1_ff <= rect_x0_ff;
         rect_y1_ff <= rect_y0_ff;
      end
   end

   // Stage 2: add the center in polar mode and pick the mode's position.
   logic signed [PW-1:0] center_x_in;
   logic signed [PW-1:0] center_y_in;
   logic signed [PW-1:0] pos_x_ff;
   logic signed [PW-1:0] pos_y_ff;

   always_comb begin
      center_x_in = $signed(PW'({cfg.half_w, F'(0)}));
      center_y_in = $signed(PW'({cfg.half_h, F'(0)}));
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         pos_x_ff <= cfg.rect ? rect_x1_ff : center_x_in + off_x_ff;
         pos_y_ff <= cfg.rect ? rect_y1_ff : center_y_in + off_y_ff;
      end
   end

   assign pos_x = pos_x_ff;
   assign pos_y = pos_y_ff;

endmodule

// ----- src/dtag_wrap.sv -----
// Splits positions into pixel and fraction, wraps or clamps them and packs the table entry.
`timescale 1ns / 1ps

module dtag_wrap (
   input  logic                                  clock,
   input  logic [dtag_pkg::WRAP_STAGES-1:0]      stage_en,
   input  dtag_pkg::cfg_type                     cfg,
   input  logic signed [dtag_pkg::POS_WIDTH-1:0] pos_x,
   input  logic signed [dtag_pkg::POS_WIDTH-1:0] pos_y,
   output logic [dtag_pkg::PACKED_WIDTH-1:0]     packed_entry
);

   localparam int F   = dtag_pkg::COORD_FRAC_BITS;
   localparam int PW  = dtag_pkg::POS_WIDTH;
   localparam int SW  = dtag_pkg::SIZE_WIDTH;
   localparam int CB  = dtag_pkg::COL_BITS;
   localparam int CO  = dtag_pkg::COL_OUT_WIDTH;
   localparam int FW  = dtag_pkg::FRAC_WIDTH;
   localparam int MS  = dtag_pkg::MOD_STAGES;
   localparam int BPS = dtag_pkg::MOD_BITS_PER_STAGE;
   localparam int IXW = CO + SW + 1;

   // Unless subpixel add a half; truncate toward zero; keep top fraction bits, signed.
   function automatic dtag_pkg::axis_type split_pos(input logic signed [PW-1:0] pos,
                                                    input logic subpix);
      logic signed [PW:0] p;
      logic [PW:0]        mag;
      logic [FW-1:0]      f;
      dtag_pkg::axis_type r;
      p     = $signed({pos[PW-1], pos}) + (subpix ? '0 : $signed((PW+1)'(1 << (F - 1))));
      mag   = p[PW] ? -p : p;
      f     = mag[F-1 -: FW];
      r.neg  = p[PW];
      r.mag  = mag[F +: CB];
      r.frac = p[PW] ? -f : f;
      r.rem  = '0;
      return r;
   endfunction

   logic [SW-1:0] mod_x;
   logic [SW-1:0] mod_y;

   assign mod_x = cfg.subpixel ? cfg.width - SW'(1) : cfg.width;
   assign mod_y = cfg.subpixel ? cfg.height - SW'(1) : cfg.height;

   // Split and remainder stages, x in lane 0 and y in lane 1.
   dtag_pkg::axis_type ax_in [MS+1][2];
   dtag_pkg::axis_type ax_ff [MS+1][2];

   always_comb begin
      dtag_pkg::axis_type t;
      logic [SW-1:0]      r;
      logic [SW-1:0]      m;
      int                 bit_idx;
      ax_in[0][0] = split_pos(pos_x, cfg.subpixel);
      ax_in[0][1] = split_pos(pos_y, cfg.subpixel);
      for (int s = 1; s <= MS; s++) begin
         for (int a = 0; a < 2; a++) begin
            t = ax_ff[s-1][a];
            m = (a == 0) ? mod_x : mod_y;
            for (int j = 0; j < BPS; j++) begin
               bit_idx = CB - 1 - ((s - 1) * BPS + j);
               r = {t.rem, t.mag[bit_idx]};
               if (r >= m) begin
                  r = r - m;
               end
               t.rem = r[CO-1:0];
            end
            ax_in[s][a] = t;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= MS; s++) begin
         if (stage_en[s]) begin
            ax_ff[s][0] <= ax_in[s][0];
            ax_ff[s][1] <= ax_in[s][1];
         end
      end
   end

   // Wrap to a non-negative remainder or clamp to the edge.
   logic [CO-1:0] col_in  [2];
   logic [FW-1:0] frac_in [2];
   logic [CO-1:0] col_ff  [2];
   logic [FW-1:0] frac_ff [2];

   always_comb begin
      dtag_pkg::axis_type t;
      logic [SW-1:0]      sz;
      logic [SW-1:0]      m;
      logic [SW-1:0]      wrapped;
      logic               below;
      for (int a = 0; a < 2; a++) begin
         t       = ax_ff[MS][a];
         sz      = (a == 0) ? cfg.width : cfg.height;
         m       = (a == 0) ? mod_x : mod_y;
         below   = t.neg && (t.mag != '0);
         wrapped = (t.neg && (t.rem != '0)) ? m - {1'b0, t.rem} : {1'b0, t.rem};
         col_in[a]  = wrapped[CO-1:0];
         frac_in[a] = cfg.subpixel ? t.frac : '0;
         if (!cfg.wrap) begin
            if (cfg.subpixel) begin
               if (below) begin
                  col_in[a]  = '0;
                  frac_in[a] = '0;
               end else if (t.mag >= CB'(sz - SW'(1))) begin
                  col_in[a]  = CO'(sz - SW'(2));
                  frac_in[a] = dtag_pkg::FRAC_MAX;
               end else begin
                  col_in[a]  = t.mag[CO-1:0];
               end
            end else begin
               if (below) begin
                  col_in[a] = '0;
               end else if (t.mag > CB'(sz - SW'(1))) begin
                  col_in[a] = CO'(sz - SW'(1));
               end else begin
                  col_in[a] = t.mag[CO-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[MS+1]) begin
         col_ff[0]  <= col_in[0];
         col_ff[1]  <= col_in[1];
         frac_ff[0] <= frac_in[0];
         frac_ff[1] <= frac_in[1];
      end
   end

   // Row-major index and packing; this register is the result output.
   logic [IXW-1:0]                    index_in;
   logic [dtag_pkg::PACKED_WIDTH-1:0] packed_ff;

   assign index_in = IXW'(col_ff[0]) + col_ff[1] * IXW'(cfg.width);

   always_ff @(posedge clock) begin
      if (stage_en[MS+2]) begin
         packed_ff <= {frac_ff[0], frac_ff[1], index_in[dtag_pkg::INDEX_WIDTH-1:0]};
      end
   end

   assign packed_entry = packed_ff;

endmodule

// ----- src/displacement_table_address_gen.sv -----
// Top level of the displacement table address generator: registers, flow control, pipeline.
//
//   Channel   Direction  Handshake              Contents
//   req_*     in         req_tvalid/req_tready  ndc_x, ndc_y, norm_dist, phase_turns
//   rsp_*     out        rsp_tvalid/rsp_tready  packed_entry
//   csr_*     in         csr_we                 register index and write data
//
// One transaction enters per cycle while req_tready is high. Each one passes 27 register stages,
// the last of which drives rsp_tdata. The depth is set by the 17-stage CORDIC,
// 3 scaling stages and 7 wrap and pack stages.
// Synchronous active-high reset empties the pipeline and loads the register defaults.
// A stalled stage holds its data; any empty stage ahead of it still fills, so input
// is taken while the output register waits, as long as any stage is still empty.
`timescale 1ns / 1ps

module displacement_table_address_gen #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // req_tdata: ndc_x[19:0], ndc_y[39:20], norm_dist[59:40], phase_turns[75:60], zero pad
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [dtag_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   // rsp_tdata: packed_entry[31:0]
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [dtag_pkg::PACKED_WIDTH-1:0]      rsp_tdata,
   input  logic                                   csr_we,
   input  logic [dtag_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [dtag_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int SW = dtag_pkg::SIZE_WIDTH;
   localparam int CW = dtag_pkg::COORD_WIDTH;
   localparam int N  = dtag_pkg::PIPE_STAGES;
   localparam int C0 = dtag_pkg::CORDIC_STAGES;
   localparam int S0 = C0 + dtag_pkg::SCALE_STAGES;

   // Configuration registers.
   logic [SW-1:0]                  frame_width_ff;
   logic [SW-1:0]                  frame_height_ff;
   logic                           wrap_mode_ff;
   logic                           subpixel_mode_ff;
   logic                           rect_mode_ff;
   logic [dtag_pkg::DIAG_WIDTH-1:0] half_diagonal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= SW'(640);
         frame_height_ff  <= SW'(480);
         wrap_mode_ff     <= 1'b0;
         subpixel_mode_ff <= 1'b0;
         rect_mode_ff     <= 1'b1;
         half_diagonal_ff <= dtag_pkg::DIAG_WIDTH'(26214400);
      end else if (csr_we) begin
         case (csr_index)
            dtag_pkg::REG_FRAME_WIDTH:   frame_width_ff   <= csr_wdata[SW-1:0];
            dtag_pkg::REG_FRAME_HEIGHT:  frame_height_ff  <= csr_wdata[SW-1:0];
            dtag_pkg::REG_WRAP_MODE:     wrap_mode_ff     <= csr_wdata[0];
            dtag_pkg::REG_SUBPIXEL_MODE: subpixel_mode_ff <= csr_wdata[0];
            dtag_pkg::REG_RECT_MODE:     rect_mode_ff     <= csr_wdata[0];
            dtag_pkg::REG_HALF_DIAGONAL: half_diagonal_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Saturate the frame size and derive the half sizes.
   dtag_pkg::cfg_type cfg;
   logic [SW-1:0]     width_sat;
   logic [SW-1:0]     height_sat;

   always_comb begin
      if (frame_width_ff < SW'(2)) begin
         width_sat = SW'(2);
      end else if (frame_width_ff > SW'(MAX_WIDTH)) begin
         width_sat = SW'(MAX_WIDTH);
      end else begin
         width_sat = frame_width_ff;
      end
      if (frame_height_ff < SW'(2)) begin
         height_sat = SW'(2);
      end else if (frame_height_ff > SW'(MAX_HEIGHT)) begin
         height_sat = SW'(MAX_HEIGHT);
      end else begin
         height_sat = frame_height_ff;
      end
      cfg.width     = width_sat;
      cfg.height    = height_sat;
      cfg.half_w    = width_sat[SW-1:1];
      cfg.half_h    = height_sat[SW-1:1];
      cfg.wrap      = wrap_mode_ff;
      cfg.subpixel  = subpixel_mode_ff;
      cfg.rect      = rect_mode_ff;
      cfg.half_diag = half_diagonal_ff;
   end

   // Per-stage valid bits; a stage loads when it is empty or its successor moves.
   logic [N-1:0] valid_ff;
   logic [N-1:0] valid_in;
   logic [N-1:0] advance;

   always_comb begin
      advance[N-1] = !valid_ff[N-1] || rsp_tready;
      for (int i = N - 2; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
      valid_in = {valid_ff[N-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (advance & valid_in) | (~advance & valid_ff);
      end
   end

   assign req_tready = advance[0];
   assign rsp_tvalid = valid_ff[N-1];

   // Datapath.
   dtag_pkg::payload_type                     req_pay;
   dtag_pkg::payload_type                     cordic_pay;
   logic signed [dtag_pkg::CORDIC_WIDTH-1:0]  cordic_x;
   logic signed [dtag_pkg::CORDIC_WIDTH-1:0]  cordic_y;
   logic                                      cordic_neg;
   logic signed [dtag_pkg::POS_WIDTH-1:0]     pos_x;
   logic signed [dtag_pkg::POS_WIDTH-1:0]     pos_y;

   assign req_pay.ndc_x     = $signed(req_tdata[CW-1:0]);
   assign req_pay.ndc_y     = $signed(req_tdata[2*CW-1:CW]);
   assign req_pay.norm_dist = $signed(req_tdata[3*CW-1:2*CW]);

   dtag_cordic u_cordic (
      .clock    (clock),
      .stage_en (advance[C0-1:0]),
      .in_pay   (req_pay),
      .in_phase (req_tdata[3*CW +: dtag_pkg::PHASE_WIDTH]),
      .out_x    (cordic_x),
      .out_y    (cordic_y),
      .out_neg  (cordic_neg),
      .out_pay  (cordic_pay)
   );

   dtag_scale u_scale (
      .clock    (clock),
      .stage_en (advance[S0-1:C0]),
      .cfg      (cfg),
      .in_x     (cordic_x),
      .in_y     (cordic_y),
      .in_neg   (cordic_neg),
      .in_pay   (cordic_pay),
      .pos_x    (pos_x),
      .pos_y    (pos_y)
   );

   dtag_wrap u_wrap (
      .clock        (clock),
      .stage_en     (advance[N-1:S0]),
      .cfg          (cfg),
      .pos_x        (pos_x),
      .pos_y        (pos_y),
      .packed_entry (rsp_tdata)
   );

endmodule
